/* rtl/tlps_pkg.sv */
// ----------------------------------------------------------------------------
// tlps_pkg - shared types and constants of the text line segmenter
// Pixel and result item types, classified item flags, default sizes.
// ----------------------------------------------------------------------------
package tlps_pkg;

	localparam int DEF_MAX_COLS  = 4096;
	localparam int DEF_MAX_ROWS  = 4096;
	localparam int DEF_MAX_LINES = 512;

	// queue depths between the parts
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	localparam logic [7:0] OBJECT_CODE_RESET = 8'd1;

	localparam int IDX_W   = 9;
	localparam int COORD_W = 12;

	typedef struct packed {
		logic [7:0] pixel_code;
		logic       end_of_row;
		logic       end_of_image;
	} tlps_pixel_t;

	typedef struct packed {
		logic               line_valid;
		logic [IDX_W-1:0]   line_index;
		logic [COORD_W-1:0] row_start;
		logic [COORD_W-1:0] row_end;
		logic [COORD_W-1:0] col_start;
		logic [COORD_W-1:0] col_end;
		logic               image_done;
		logic               line_overflow;
	} tlps_result_t;

	// classified pixel as passed from front to back
	typedef struct packed {
		logic ink;
		logic eor;
		logic eoi;
	} tlps_cls_t;

endpackage

/* rtl/tlps_fifo.sv */
// ----------------------------------------------------------------------------
// tlps_fifo - small register queue
// Holds up to DEPTH entries in flops; full and empty come from a count.
// ----------------------------------------------------------------------------
module tlps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [NW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NW'(DEPTH))
		else $error("queue count beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a push");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a pop");

endmodule

/* rtl/tlps_front.sv */
// ----------------------------------------------------------------------------
// tlps_front - pixel intake and classification
// Holds the object code, tags each pixel as ink or not and gives it its column.
// ----------------------------------------------------------------------------
module tlps_front #(
	parameter int MAX_COLS = tlps_pkg::DEF_MAX_COLS,
	localparam int CW      = $clog2(MAX_COLS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata,
	input  logic                 in_push,
	input  tlps_pkg::tlps_pixel_t in_pixel,
	input  logic                 q_full,
	output logic                 q_push,
	output tlps_pkg::tlps_cls_t  q_cls,
	output logic [CW-1:0]        q_col
);
	import tlps_pkg::*;

	logic [7:0]    object_code_q;
	logic [CW-1:0] col_q;
	logic          accept;
	logic          row_end;

	assign accept  = in_push && !q_full;
	assign row_end = in_pixel.end_of_row || in_pixel.end_of_image;

	assign q_push    = accept;
	assign q_cls.ink = (in_pixel.pixel_code == object_code_q);
	assign q_cls.eor = in_pixel.end_of_row;
	assign q_cls.eoi = in_pixel.end_of_image;
	assign q_col     = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_code_q <= OBJECT_CODE_RESET;
			col_q         <= '0;
		end else begin
			if (cfg_we) begin
				object_code_q <= cfg_wdata;
			end
			if (accept) begin
				if (row_end) begin
					col_q <= '0;
				end else if (col_q < CW'(MAX_COLS - 1)) begin
					// column saturates on over-long rows
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/tlps_back.sv */
// ----------------------------------------------------------------------------
// tlps_back - line tracker
// Follows rows with ink, keeps the open line's extent and forms line records.
// ----------------------------------------------------------------------------
module tlps_back #(
	parameter int MAX_COLS  = tlps_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS  = tlps_pkg::DEF_MAX_ROWS,
	parameter int MAX_LINES = tlps_pkg::DEF_MAX_LINES,
	localparam int CW       = $clog2(MAX_COLS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  tlps_pkg::tlps_cls_t   q_cls,
	input  logic [CW-1:0]         q_col,
	output logic                  q_pop,
	input  logic                  r_full,
	output logic                  r_push,
	output tlps_pkg::tlps_result_t r_item
);
	import tlps_pkg::*;

	localparam int RW = $clog2(MAX_ROWS);
	localparam int LW = $clog2(MAX_LINES + 1);

	logic [RW-1:0] row_q;
	logic          has_ink_q;
	logic          inside_q;
	logic [RW-1:0] first_q;
	logic [CW-1:0] min_q;
	logic [CW-1:0] max_q;
	logic [LW-1:0] lines_q;
	logic          ovf_q;

	logic          step;
	logic          row_done;
	logic          inside_n;
	logic [RW-1:0] first_n;
	logic [CW-1:0] min_n;
	logic [CW-1:0] max_n;
	logic          has_ink_n;
	logic          close;
	logic          report;
	logic          ovf_n;
	logic [RW-1:0] re;
	logic [RW-1:0] row_prev;
	logic [31:0]   idx_w;
	logic [31:0]   rs_w;
	logic [31:0]   re_w;
	logic [31:0]   cs_w;
	logic [31:0]   ce_w;

	// results wait in the output queue, so stall when it has no room
	assign step     = !q_empty && !r_full;
	assign q_pop    = step;
	assign row_done = q_cls.eor || q_cls.eoi;

	always_comb begin
		inside_n  = inside_q;
		first_n   = first_q;
		min_n     = min_q;
		max_n     = max_q;
		has_ink_n = has_ink_q;
		if (q_cls.ink) begin
			if (!inside_q) begin
				inside_n = 1'b1;
				first_n  = row_q;
				min_n    = q_col;
				max_n    = q_col;
			end else begin
				if (q_col < min_q) min_n = q_col;
				if (q_col > max_q) max_n = q_col;
			end
			has_ink_n = 1'b1;
		end
	end

	always_comb begin
		row_prev = row_q - 1'b1;
		close    = row_done && inside_n && (!has_ink_n || q_cls.eoi);
		report   = close && (lines_q < LW'(MAX_LINES));
		ovf_n    = ovf_q || (close && !report);
		if (has_ink_n) begin
			re = row_q;
		end else if (row_q == '0 || row_prev < first_n) begin
			// empty row after a saturated row count
			re = first_n;
		end else begin
			re = row_prev;
		end
	end

	always_comb begin
		idx_w = 32'(lines_q);
		rs_w  = 32'(first_n);
		re_w  = 32'(re);
		cs_w  = 32'(min_n);
		ce_w  = 32'(max_n);
		r_push              = step && row_done && (report || q_cls.eoi);
		r_item.line_valid    = report;
		r_item.line_index    = report ? idx_w[IDX_W-1:0] : '0;
		r_item.row_start     = report ? rs_w[COORD_W-1:0] : '0;
		r_item.row_end       = report ? re_w[COORD_W-1:0] : '0;
		r_item.col_start     = report ? cs_w[COORD_W-1:0] : '0;
		r_item.col_end       = report ? ce_w[COORD_W-1:0] : '0;
		r_item.image_done    = q_cls.eoi;
		r_item.line_overflow = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			has_ink_q <= 1'b0;
			inside_q  <= 1'b0;
			first_q   <= '0;
			min_q     <= '1;
			max_q     <= '0;
			lines_q   <= '0;
			ovf_q     <= 1'b0;
		end else if (step) begin
			if (!row_done) begin
				inside_q  <= inside_n;
				first_q   <= first_n;
				min_q     <= min_n;
				max_q     <= max_n;
				has_ink_q <= has_ink_n;
			end else if (q_cls.eoi) begin
				// image finished, back to the reset picture
				row_q     <= '0;
				has_ink_q <= 1'b0;
				inside_q  <= 1'b0;
				first_q   <= '0;
				min_q     <= '1;
				max_q     <= '0;
				lines_q   <= '0;
				ovf_q     <= 1'b0;
			end else begin
				has_ink_q <= 1'b0;
				ovf_q     <= ovf_n;
				if (row_q < RW'(MAX_ROWS - 1)) begin
					row_q <= row_q + 1'b1;
				end
				if (close) begin
					inside_q <= 1'b0;
					first_q  <= '0;
					min_q    <= '1;
					max_q    <= '0;
				end else begin
					inside_q <= inside_n;
					first_q  <= first_n;
					min_q    <= min_n;
					max_q    <= max_n;
				end
				if (report) begin
					lines_q <= lines_q + 1'b1;
				end
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(r_push && r_full))
		else $error("result formed while output queue full");
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && q_cls.eoi) |=> (!inside_q && lines_q == '0 && !ovf_q))
		else $error("line state not cleared after end of image");
	a_extent: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> (min_q <= max_q && first_q <= row_q))
		else $error("open line extent inconsistent");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (lines_q == LW'(MAX_LINES)))
		else $error("overflow flagged before line table full");

endmodule

/* rtl/text_line_projection_segmenter.sv */
// ----------------------------------------------------------------------------
// text_line_projection_segmenter - text line finder by row projection
// Takes a binary document image in raster order and reports each text line.
// ----------------------------------------------------------------------------
// Input channel: one pixel item a cycle on pixel, taken at an edge with push
// high and full low. Mark the last pixel of each row with end_of_row and the
// last pixel of the image with end_of_image (which also ends its row).
// Result channel: while empty is low the oldest line record is on result;
// pop takes it. A record appears when a row without ink closes a line while
// the line table has room, and one always comes with the end-of-image pixel.
// The closing pixel is registered in the intake queue and its record in the
// output queue. Throughput: one pixel per cycle while the output queue has
// room, set by the tracker's combinational compare and min/max update.
// A four-entry queue sits between intake and tracker and a two-entry queue
// holds records; when pop stays low, records collect there, the tracker
// stops and full rises once the intake queue fills. No pixel is dropped.
// Reset clears all line state and both queues and sets object_code to 1;
// cfg_we writes object_code and should be used only while the block is idle.
// ----------------------------------------------------------------------------
module text_line_projection_segmenter #(
	parameter int MAX_COLS  = tlps_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS  = tlps_pkg::DEF_MAX_ROWS,
	parameter int MAX_LINES = tlps_pkg::DEF_MAX_LINES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [7:0]             cfg_wdata,
	input  logic                   push,
	input  tlps_pkg::tlps_pixel_t  pixel,
	output logic                   full,
	output logic                   empty,
	input  logic                   pop,
	output tlps_pkg::tlps_result_t result
);
	import tlps_pkg::*;

	localparam int CW   = $clog2(MAX_COLS);
	localparam int MIDW = $bits(tlps_cls_t) + CW;
	localparam int OUTW = $bits(tlps_result_t);

	logic          mid_push;
	tlps_cls_t     front_cls;
	logic [CW-1:0] front_col;
	logic          mid_full;
	logic          mid_empty;
	logic          mid_pop;
	logic [MIDW-1:0] mid_rdata;
	tlps_cls_t     back_cls;
	logic [CW-1:0] back_col;
	logic          res_push;
	tlps_result_t  res_item;
	logic          res_full;
	logic [OUTW-1:0] res_rdata;

	assign full = mid_full;

	tlps_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_push   (push),
		.in_pixel  (pixel),
		.q_full    (mid_full),
		.q_push    (mid_push),
		.q_cls     (front_cls),
		.q_col     (front_col)
	);

	tlps_fifo #(
		.WIDTH (MIDW),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  ({front_cls, front_col}),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign back_cls = tlps_cls_t'(mid_rdata[MIDW-1:CW]);
	assign back_col = mid_rdata[CW-1:0];

	tlps_back #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.MAX_LINES (MAX_LINES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (mid_empty),
		.q_cls   (back_cls),
		.q_col   (back_col),
		.q_pop   (mid_pop),
		.r_full  (res_full),
		.r_push  (res_push),
		.r_item  (res_item)
	);

	tlps_fifo #(
		.WIDTH (OUTW),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_item),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign result = tlps_result_t'(res_rdata);

endmodule
